>>> hdl/rbt_pkg.sv
// shared types and constants of the resource barrier tracker
// used by rbt_front, rbt_queue, rbt_back and resource_barrier_tracker_top
package rbt_pkg;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;
  localparam logic [8:0]  NoPass   = 9'd256;

  typedef enum logic [1:0] {
    OP_DECL  = 2'd0,
    OP_ACC   = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    K_PRE   = 2'd0,
    K_TRAIL = 2'd1,
    K_EDGE  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC_RD,
    S_ACC_EX,
    S_EDGE,
    S_FL_EX,
    S_FL_END
  } bk_state_e;

  // classified command handed from front to back
  typedef struct packed {
    op_e        op;
    logic       is_buf;
    logic [4:0] idx;
    logic [7:0] pass;
    logic [1:0] queue;
    logic [4:0] st;
    logic       imported;
    logic       ext_read;
    logic [4:0] ext_state;
    logic       swapchain;
    logic [6:0] alias_src;
  } cmd_t;

  // per-resource record held in the back memory
  typedef struct packed {
    logic [4:0] st;
    logic [1:0] queue;
    logic [8:0] last_pass;
    logic       imported;
    logic       ext_read;
    logic       swapchain;
    logic [4:0] ext_state;
    logic [6:0] alias_src;
  } rec_t;

  typedef struct packed {
    kind_e      kind;
    logic       is_buf;
    logic [4:0] idx;
    logic [4:0] old_st;
    logic [4:0] new_st;
    logic       agg;
    logic       aliasing;
    logic [1:0] from_q;
    logic [1:0] to_q;
    logic [8:0] prod;
    logic [7:0] cons;
    logic       last;
  } res_t;

endpackage

>>> hdl/rbt_front.sv
// input side: unpacks, range checks and classifies stream items
// depends on rbt_pkg
module rbt_front #(
  parameter int unsigned RESOURCES_PER_KIND = 32,
  parameter int unsigned MAX_PASSES         = 256
) (
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [rbt_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic [1:0]                   s_axis_tuser_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output rbt_pkg::cmd_t                q_cmd_o
);

  rbt_pkg::cmd_t cmd;
  logic          keep;

  always_comb begin
    cmd.op        = rbt_pkg::op_e'(s_axis_tuser_i);
    cmd.is_buf    = s_axis_tdata_i[0];
    cmd.idx       = s_axis_tdata_i[5:1];
    cmd.pass      = s_axis_tdata_i[13:6];
    cmd.queue     = s_axis_tdata_i[15:14];
    cmd.st        = s_axis_tdata_i[20:16];
    cmd.imported  = s_axis_tdata_i[21];
    cmd.ext_read  = s_axis_tdata_i[22];
    cmd.ext_state = s_axis_tdata_i[27:23];
    cmd.swapchain = s_axis_tdata_i[28];
    cmd.alias_src = s_axis_tdata_i[35:29];
    keep = 1'b0;
    case (cmd.op)
      rbt_pkg::OP_DECL:  keep = 32'(cmd.idx) < RESOURCES_PER_KIND;
      rbt_pkg::OP_ACC:   keep = (32'(cmd.idx) < RESOURCES_PER_KIND) &&
                                (32'(cmd.pass) < MAX_PASSES);
      rbt_pkg::OP_FLUSH: keep = 1'b1;
      default:           keep = 1'b0;
    endcase
  end

  // items that do nothing are taken and dropped here
  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i && keep;
  assign q_cmd_o         = cmd;

endmodule

>>> hdl/rbt_queue.sv
// two-entry command queue between front and back
// depends on rbt_pkg
module rbt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rbt_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output rbt_pkg::cmd_t cmd_o
);

  rbt_pkg::cmd_t ent_q [2];
  logic          wp_q, wp_d, rp_q, rp_d;
  logic [1:0]    cnt_q, cnt_d;

  always_comb begin
    wp_d  = wp_q ^ push_i;
    rp_d  = rp_q ^ pop_i;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= cmd_i;
    end
  end

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign cmd_o   = ent_q[rp_q];

endmodule

>>> hdl/rbt_back.sv
// back end: record memory, access/flush sequencer and output register
// depends on rbt_pkg
module rbt_back #(
  parameter int unsigned RESOURCES_PER_KIND = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_pop_o,
  input  rbt_pkg::cmd_t q_cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rbt_pkg::res_t out_res_o
);

  localparam int unsigned Entries = 2 * RESOURCES_PER_KIND;
  localparam int unsigned AddrW   = (Entries > 1) ? $clog2(Entries) : 1;

  rbt_pkg::rec_t mem [Entries];
  rbt_pkg::rec_t rdata_q, rec_q, rec_d, wdata;
  logic [AddrW-1:0] raddr, waddr, fl_q, fl_d;
  logic             we;
  logic [Entries-1:0] decl_q, decl_d;

  rbt_pkg::bk_state_e state_q, state_d;
  rbt_pkg::cmd_t      cmd_q, cmd_d;
  rbt_pkg::res_t      out_q, out_d, edge_q, edge_d, pend_q, pend_d, emit_res;
  logic               out_v_q, out_v_d, pend_v_q, pend_v_d, emit, can_emit;

  function automatic logic [AddrW-1:0] entry_addr(logic is_buf, logic [4:0] idx);
    return is_buf ? AddrW'(RESOURCES_PER_KIND + 32'(idx)) : AddrW'(idx);
  endfunction

  // alias code: 0 none, 1-32 texture, 33-64 buffer
  function automatic logic alias_ok(logic [6:0] code);
    logic [6:0] i;
    i = (code <= 7'd32) ? code - 7'd1 : code - 7'd33;
    return (code != 7'd0) && (code <= 7'd64) && (32'(i) < RESOURCES_PER_KIND);
  endfunction

  function automatic logic [AddrW-1:0] alias_addr(logic [6:0] code);
    logic [4:0] i;
    i = (code <= 7'd32) ? 5'(code - 7'd1) : 5'(code - 7'd33);
    return entry_addr(code > 7'd32, i);
  endfunction

  logic [AddrW-1:0] cur_addr;
  logic       first, aok, bv, ev, prior;
  logic [4:0] old_st, new_st;
  logic       agg, ali, found;

  assign can_emit = !out_v_q || out_ready_i;
  assign cur_addr = entry_addr(cmd_q.is_buf, cmd_q.idx);

  // access decision, rec_q is the resource, rdata_q the alias source
  always_comb begin
    first  = (rec_q.last_pass == rbt_pkg::NoPass) ||
             (rec_q.last_pass == {1'b0, cmd_q.pass});
    aok    = alias_ok(rec_q.alias_src);
    bv     = 1'b0;
    old_st = rec_q.st;
    agg    = 1'b1;
    ali    = 1'b0;
    if (!cmd_q.is_buf) begin
      if (first && aok) begin
        bv     = 1'b1;
        old_st = rdata_q.st;
        ali    = 1'b1;
      end else if (rec_q.st != cmd_q.st) begin
        bv  = 1'b1;
        agg = !rec_q.swapchain;
      end
    end else begin
      if (first && aok) begin
        old_st = rdata_q.st;
      end
      bv = old_st != cmd_q.st;
    end
    new_st = bv ? cmd_q.st : rec_q.st;
    prior  = rec_q.imported || (rec_q.last_pass != rbt_pkg::NoPass);
    ev     = prior && (rec_q.queue != cmd_q.queue);
    found  = decl_q[fl_q] && rdata_q.ext_read && (rdata_q.st != rdata_q.ext_state);
  end

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    rec_d    = rec_q;
    fl_d     = fl_q;
    decl_d   = decl_q;
    edge_d   = edge_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    q_pop_o  = 1'b0;
    raddr    = cur_addr;
    we       = 1'b0;
    waddr    = cur_addr;
    wdata    = rec_q;
    emit     = 1'b0;
    emit_res = edge_q;

    case (state_q)
      rbt_pkg::S_IDLE: begin
        raddr = entry_addr(q_cmd_i.is_buf, q_cmd_i.idx);
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          case (q_cmd_i.op)
            rbt_pkg::OP_DECL: begin
              we              = 1'b1;
              waddr           = raddr;
              wdata.st        = q_cmd_i.st;
              wdata.queue     = q_cmd_i.queue;
              wdata.last_pass = rbt_pkg::NoPass;
              wdata.imported  = q_cmd_i.imported;
              wdata.ext_read  = q_cmd_i.ext_read;
              wdata.swapchain = q_cmd_i.swapchain;
              wdata.ext_state = q_cmd_i.ext_state;
              wdata.alias_src = q_cmd_i.alias_src;
              decl_d[raddr]   = 1'b1;
            end
            rbt_pkg::OP_ACC: begin
              if (decl_q[raddr]) begin
                state_d = rbt_pkg::S_ACC_RD;
              end
            end
            rbt_pkg::OP_FLUSH: begin
              raddr    = '0;
              fl_d     = '0;
              pend_v_d = 1'b0;
              state_d  = rbt_pkg::S_FL_EX;
            end
            default: ;
          endcase
        end
      end

      rbt_pkg::S_ACC_RD: begin
        rec_d   = rdata_q;
        raddr   = alias_addr(rdata_q.alias_src);
        state_d = rbt_pkg::S_ACC_EX;
      end

      rbt_pkg::S_ACC_EX: begin
        raddr = alias_addr(rec_q.alias_src);
        edge_d.kind     = rbt_pkg::K_EDGE;
        edge_d.is_buf   = cmd_q.is_buf;
        edge_d.idx      = cmd_q.idx;
        edge_d.old_st   = '0;
        edge_d.new_st   = '0;
        edge_d.agg      = 1'b0;
        edge_d.aliasing = 1'b0;
        edge_d.from_q   = rec_q.queue;
        edge_d.to_q     = cmd_q.queue;
        edge_d.prod     = rec_q.last_pass;
        edge_d.cons     = cmd_q.pass;
        edge_d.last     = 1'b1;
        emit_res.kind     = rbt_pkg::K_PRE;
        emit_res.is_buf   = cmd_q.is_buf;
        emit_res.idx      = cmd_q.idx;
        emit_res.old_st   = old_st;
        emit_res.new_st   = cmd_q.st;
        emit_res.agg      = agg;
        emit_res.aliasing = ali;
        emit_res.from_q   = '0;
        emit_res.to_q     = '0;
        emit_res.prod     = '0;
        emit_res.cons     = '0;
        emit_res.last     = !ev;
        if (!(bv || ev) || can_emit) begin
          we              = 1'b1;
          wdata.st        = new_st;
          wdata.queue     = cmd_q.queue;
          wdata.last_pass = {1'b0, cmd_q.pass};
          if (bv) begin
            emit    = 1'b1;
            state_d = ev ? rbt_pkg::S_EDGE : rbt_pkg::S_IDLE;
          end else if (ev) begin
            emit     = 1'b1;
            emit_res = edge_d;
            state_d  = rbt_pkg::S_IDLE;
          end else begin
            state_d = rbt_pkg::S_IDLE;
          end
        end
      end

      rbt_pkg::S_EDGE: begin
        emit_res = edge_q;
        if (can_emit) begin
          emit    = 1'b1;
          state_d = rbt_pkg::S_IDLE;
        end
      end

      // one entry a cycle unless stalled; pend holds a barrier till the next
      rbt_pkg::S_FL_EX: begin
        raddr    = fl_q;
        emit_res = pend_q;
        emit_res.last = 1'b0;
        if (!(found && pend_v_q) || can_emit) begin
          if (found) begin
            we       = 1'b1;
            waddr    = fl_q;
            wdata    = rdata_q;
            wdata.st = rdata_q.ext_state;
            emit     = pend_v_q;
            pend_v_d = 1'b1;
            pend_d.kind     = rbt_pkg::K_TRAIL;
            pend_d.is_buf   = 32'(fl_q) >= RESOURCES_PER_KIND;
            pend_d.idx      = (32'(fl_q) >= RESOURCES_PER_KIND) ?
                              5'(32'(fl_q) - RESOURCES_PER_KIND) : 5'(fl_q);
            pend_d.old_st   = rdata_q.st;
            pend_d.new_st   = rdata_q.ext_state;
            pend_d.agg      = (32'(fl_q) >= RESOURCES_PER_KIND) || !rdata_q.swapchain;
            pend_d.aliasing = 1'b0;
            pend_d.from_q   = '0;
            pend_d.to_q     = '0;
            pend_d.prod     = '0;
            pend_d.cons     = '0;
            pend_d.last     = 1'b1;
          end
          if (32'(fl_q) == Entries - 1) begin
            state_d = rbt_pkg::S_FL_END;
          end else begin
            fl_d  = fl_q + AddrW'(1);
            raddr = fl_d;
          end
        end
      end

      rbt_pkg::S_FL_END: begin
        emit_res = pend_q;
        if (!pend_v_q) begin
          state_d = rbt_pkg::S_IDLE;
        end else if (can_emit) begin
          emit     = 1'b1;
          pend_v_d = 1'b0;
          state_d  = rbt_pkg::S_IDLE;
        end
      end

      default: state_d = rbt_pkg::S_IDLE;
    endcase

    out_d   = emit ? emit_res : out_q;
    out_v_d = emit ? 1'b1 : (out_v_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rbt_pkg::S_IDLE;
      decl_q   <= '0;
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
      fl_q     <= '0;
    end else begin
      state_q  <= state_d;
      decl_q   <= decl_d;
      out_v_q  <= out_v_d;
      pend_v_q <= pend_v_d;
      fl_q     <= fl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    rec_q  <= rec_d;
    edge_q <= edge_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;

endmodule

>>> hdl/resource_barrier_tracker_top.sv
// back end: declare writes straight from idle; access does the entry read, then the alias
// read of the record memory, then decides, with an edge state when it gives barrier and edge
// flush: sweeps every record entry in order, one entry a cycle unless the output stalls
// a two-entry queue lets the front take items while the back works
// reset clears the declared bits, queue and sequencer at once; no clearing pass
module resource_barrier_tracker_top #(
  parameter int unsigned RESOURCES_PER_KIND = 32,
  parameter int unsigned MAX_PASSES         = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // res_is_buffer, res_index, pass_index, queue_id, state_code, imported,
  // ext_read, ext_state, swapchain, alias_source
  input  logic [rbt_pkg::InDataW-1:0]   s_axis_tdata_i,
  // opcode
  input  logic [1:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // out_is_buffer, out_index, old_state, new_state, agglomerate, aliasing,
  // from_queue, to_queue, producer_pass, consumer_pass
  output logic [rbt_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // kind
  output logic [1:0]                    m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);

  logic          push, full, qv, pop;
  rbt_pkg::cmd_t fcmd, bcmd;
  rbt_pkg::res_t res;

  rbt_front #(
    .RESOURCES_PER_KIND(RESOURCES_PER_KIND),
    .MAX_PASSES        (MAX_PASSES)
  ) u_front (
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .q_full_i       (full),
    .q_push_o       (push),
    .q_cmd_o        (fcmd)
  );

  rbt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (fcmd),
    .full_o (full),
    .valid_o(qv),
    .pop_i  (pop),
    .cmd_o  (bcmd)
  );

  rbt_back #(
    .RESOURCES_PER_KIND(RESOURCES_PER_KIND)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (qv),
    .q_pop_o    (pop),
    .q_cmd_i    (bcmd),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_res_o  (res)
  );

  assign m_axis_tdata_o = {1'b0, res.cons, res.prod, res.to_q, res.from_q, res.aliasing,
                           res.agg, res.new_st, res.old_st, res.idx, res.is_buf};
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.last;

endmodule

>>> tb/testbench.sv
// self-checking testbench for resource_barrier_tracker_top
// predicts barriers and queue edges per transfer; needs rbt_pkg and the rtl only
`timescale 1ns / 1ps

module testbench;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid_i = 1'b0;
  logic                         s_axis_tready_o;
  // res_is_buffer, res_index, pass_index, queue_id, state_code, imported,
  // ext_read, ext_state, swapchain, alias_source
  logic [rbt_pkg::InDataW-1:0]  s_axis_tdata_i = '0;
  // opcode
  logic [1:0]                   s_axis_tuser_i = rbt_pkg::OP_NONE;
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i = 1'b0;
  // out_is_buffer, out_index, old_state, new_state, agglomerate, aliasing,
  // from_queue, to_queue, producer_pass, consumer_pass
  logic [rbt_pkg::OutDataW-1:0] m_axis_tdata_o;
  // kind
  logic [1:0]                   m_axis_tuser_o;
  logic                         m_axis_tlast_o;

  resource_barrier_tracker_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct {
    logic [1:0] kind;
    logic       is_buf;
    logic [4:0] idx;
    logic [4:0] old_st;
    logic [4:0] new_st;
    logic       agg;
    logic       aliasing;
    logic [1:0] from_q;
    logic [1:0] to_q;
    logic [8:0] prod;
    logic [7:0] cons;
    logic       lst;
  } barrier_t;

  barrier_t expected_barriers[$];
  int       mismatches = 0;

  // tracked copy of the resource records
  logic       trk_decl[64];
  logic [4:0] trk_st[64];
  logic [1:0] trk_q[64];
  logic [8:0] trk_last[64];
  logic       trk_imp[64];
  logic       trk_er[64];
  logic       trk_sw[64];
  logic [4:0] trk_ext[64];
  logic [6:0] trk_alias[64];

  int burst_left = 0;
  int pass_ctr = 0;

  function automatic int alias_slot(logic [6:0] code);
    if (code == 0 || code > 64) return -1;
    if (code <= 32) return code - 1;
    return code - 1;
  endfunction

  function automatic void push_barrier(logic [1:0] kind, logic is_buf, logic [4:0] idx,
                                       logic [4:0] olds, logic [4:0] news, logic agg,
                                       logic ali, logic [1:0] fq, logic [1:0] tq,
                                       logic [8:0] prod, logic [7:0] cons);
    barrier_t b;
    b.kind = kind; b.is_buf = is_buf; b.idx = idx; b.old_st = olds; b.new_st = news;
    b.agg = agg; b.aliasing = ali; b.from_q = fq; b.to_q = tq; b.prod = prod;
    b.cons = cons; b.lst = 1'b0;
    expected_barriers.push_back(b);
  endfunction

  function automatic void predict_barriers(logic [1:0] op,
                                           logic [rbt_pkg::InDataW-1:0] d);
    logic       isb = d[0];
    logic [4:0] idx = d[5:1];
    logic [7:0] pass = d[13:6];
    logic [1:0] q = d[15:14];
    logic [4:0] st = d[20:16];
    int         before_n = expected_barriers.size();
    int         e = isb * 32 + idx;
    int         a;
    logic       first;
    logic [4:0] olds;
    logic [8:0] lt;
    if (op == rbt_pkg::OP_DECL) begin
      trk_decl[e] = 1'b1; trk_st[e] = st; trk_q[e] = q; trk_last[e] = rbt_pkg::NoPass;
      trk_imp[e] = d[21]; trk_er[e] = d[22]; trk_ext[e] = d[27:23];
      trk_sw[e] = d[28]; trk_alias[e] = d[35:29];
    end else if (op == rbt_pkg::OP_ACC && trk_decl[e]) begin
      lt = trk_last[e];
      first = (lt == rbt_pkg::NoPass) || (lt == {1'b0, pass});
      a = alias_slot(trk_alias[e]);
      if (!isb) begin
        if (first && a >= 0) begin
          push_barrier(rbt_pkg::K_PRE, 1'b0, idx, trk_st[a], st, 1'b1, 1'b1, 2'd0, 2'd0,
                       9'd0, 8'd0);
          trk_st[e] = st;
        end else if (trk_st[e] != st) begin
          push_barrier(rbt_pkg::K_PRE, 1'b0, idx, trk_st[e], st, !trk_sw[e], 1'b0, 2'd0,
                       2'd0, 9'd0, 8'd0);
          trk_st[e] = st;
        end
      end else begin
        olds = (first && a >= 0) ? trk_st[a] : trk_st[e];
        if (olds != st) begin
          push_barrier(rbt_pkg::K_PRE, 1'b1, idx, olds, st, 1'b1, 1'b0, 2'd0, 2'd0,
                       9'd0, 8'd0);
          trk_st[e] = st;
        end
      end
      if ((trk_imp[e] || lt != rbt_pkg::NoPass) && trk_q[e] != q)
        push_barrier(rbt_pkg::K_EDGE, isb, idx, 5'd0, 5'd0, 1'b0, 1'b0, trk_q[e], q, lt,
                     pass);
      trk_q[e] = q;
      trk_last[e] = {1'b0, pass};
    end else if (op == rbt_pkg::OP_FLUSH) begin
      for (int i = 0; i < 64; i++) begin
        if (trk_decl[i] && trk_er[i] && trk_st[i] != trk_ext[i]) begin
          push_barrier(rbt_pkg::K_TRAIL, 1'(i / 32), 5'(i % 32), trk_st[i], trk_ext[i],
                       !(i < 32 && trk_sw[i]), 1'b0, 2'd0, 2'd0, 9'd0, 8'd0);
          trk_st[i] = trk_ext[i];
        end
      end
    end
    if (expected_barriers.size() > before_n)
      expected_barriers[expected_barriers.size() - 1].lst = 1'b1;
  endfunction

  function automatic logic [rbt_pkg::InDataW-1:0] pack_item(
      logic isb, logic [4:0] idx, logic [7:0] pass, logic [1:0] q, logic [4:0] st,
      logic imp, logic er, logic [4:0] es, logic sw, logic [6:0] al);
    return {4'd0, al, sw, es, er, imp, st, q, pass, idx, isb};
  endfunction

  task automatic send_item(rbt_pkg::op_e op, logic [rbt_pkg::InDataW-1:0] d);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= d;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_barriers(op, d);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // gap between bursts, sometimes none
      int gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(0, 12);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic declare_res(logic isb, logic [4:0] idx, logic [1:0] q, logic [4:0] st,
                             logic imp, logic er, logic [4:0] es, logic sw, logic [6:0] al);
    send_item(rbt_pkg::OP_DECL, pack_item(isb, idx, 8'd0, q, st, imp, er, es, sw, al));
  endtask

  task automatic access_res(logic isb, logic [4:0] idx, logic [7:0] pass, logic [1:0] q,
                            logic [4:0] st);
    send_item(rbt_pkg::OP_ACC, pack_item(isb, idx, pass, q, st, 1'b0, 1'b0, 5'd0, 1'b0,
                                         7'd0));
  endtask

  task automatic report_mismatch(string what, int got, int exp_v);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
    mismatches++;
  endtask

  // receiver stall pattern
  logic [15:0] stall_pat = 16'b1100_0000_1010_0000;
  int          stall_mode = 0;
  always @(posedge clk_i) begin
    stall_pat <= {stall_pat[14:0], stall_pat[15]};
    m_axis_tready_i <= (stall_mode == 0) ? 1'b1 : !stall_pat[15];
  end

  always @(posedge clk_i) begin
    barrier_t x;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_barriers.size() == 0) begin
        report_mismatch("unexpected transfer kind", m_axis_tuser_o, -1);
      end else begin
        x = expected_barriers.pop_front();
        if (m_axis_tuser_o != x.kind) report_mismatch("kind", m_axis_tuser_o, x.kind);
        if (m_axis_tdata_o[0] != x.is_buf) report_mismatch("is_buf", m_axis_tdata_o[0], x.is_buf);
        if (m_axis_tdata_o[5:1] != x.idx) report_mismatch("index", m_axis_tdata_o[5:1], x.idx);
        if (m_axis_tdata_o[10:6] != x.old_st)
          report_mismatch("old_state", m_axis_tdata_o[10:6], x.old_st);
        if (m_axis_tdata_o[15:11] != x.new_st)
          report_mismatch("new_state", m_axis_tdata_o[15:11], x.new_st);
        if (m_axis_tdata_o[16] != x.agg) report_mismatch("agglomerate", m_axis_tdata_o[16], x.agg);
        if (m_axis_tdata_o[17] != x.aliasing)
          report_mismatch("aliasing", m_axis_tdata_o[17], x.aliasing);
        if (m_axis_tdata_o[19:18] != x.from_q)
          report_mismatch("from_queue", m_axis_tdata_o[19:18], x.from_q);
        if (m_axis_tdata_o[21:20] != x.to_q)
          report_mismatch("to_queue", m_axis_tdata_o[21:20], x.to_q);
        if (m_axis_tdata_o[30:22] != x.prod)
          report_mismatch("producer_pass", m_axis_tdata_o[30:22], x.prod);
        if (m_axis_tdata_o[38:31] != x.cons)
          report_mismatch("consumer_pass", m_axis_tdata_o[38:31], x.cons);
        if (m_axis_tdata_o[39] != 1'b0) report_mismatch("pad bit", m_axis_tdata_o[39], 0);
        if (m_axis_tlast_o != x.lst) report_mismatch("last", m_axis_tlast_o, x.lst);
      end
    end
  end

  task automatic test_basic_barriers();
    declare_res(1'b0, 5'd0, 2'd0, 5'd0, 1'b1, 1'b1, 5'd31, 1'b1, 7'd0);
    declare_res(1'b1, 5'd31, 2'd3, 5'd31, 1'b0, 1'b1, 5'd0, 1'b0, 7'd127);
    access_res(1'b0, 5'd0, 8'd0, 2'd3, 5'd5);      // swapchain barrier plus edge from imported
    access_res(1'b0, 5'd0, 8'd255, 2'd3, 5'd5);
    access_res(1'b1, 5'd31, 8'd255, 2'd0, 5'd31);  // same state, no prior toucher
    access_res(1'b1, 5'd31, 8'hAA, 2'd2, 5'd21);
  endtask

  task automatic test_aliasing();
    declare_res(1'b0, 5'd31, 2'd1, 5'd10, 1'b0, 1'b0, 5'd0, 1'b0, 7'd64);
    access_res(1'b0, 5'd31, 8'd7, 2'd1, 5'd10);    // aliasing barrier even with equal state
    access_res(1'b0, 5'd31, 8'd7, 2'd2, 5'd10);    // still first use within the same pass
    access_res(1'b0, 5'd31, 8'd8, 2'd2, 5'd10);
    declare_res(1'b1, 5'd0, 2'd0, 5'd3, 1'b0, 1'b1, 5'd3, 1'b1, 7'd1);
    access_res(1'b1, 5'd0, 8'd9, 2'd0, 5'd5);      // source already in state, own state kept
    access_res(1'b1, 5'd0, 8'd9, 2'd0, 5'd20);
  endtask

  task automatic test_ignored_items();
    access_res(1'b1, 5'd5, 8'd3, 2'd1, 5'd4);      // never declared
    send_item(rbt_pkg::OP_NONE, pack_item(1'b1, 5'd31, 8'd255, 2'd3, 5'd31, 1'b1, 1'b1,
                                          5'd31, 1'b1, 7'd127));
    declare_res(1'b0, 5'd16, 2'd2, 5'd9, 1'b1, 1'b1, 5'd9, 1'b0, 7'd0);
  endtask

  task automatic test_flush();
    send_item(rbt_pkg::OP_FLUSH, '0);
    send_item(rbt_pkg::OP_FLUSH, '0);
  endtask

  task automatic test_random_frames();
    int accesses = 0;
    while (accesses < 60) begin
      int  nres = $urandom_range(1, 6);
      int  ents[6];
      int  npass = $urandom_range(1, 6);
      stall_mode = $urandom_range(0, 2);
      for (int r = 0; r < nres; r++) begin
        int         e = $urandom_range(0, 63);
        logic [6:0] al = 7'd0;
        int         pick = $urandom_range(0, 3);
        if (pick == 1) begin
          for (int t = 0; t < 8; t++) begin
            int c = $urandom_range(0, 63);
            if (trk_decl[c] || c == e) begin
              al = 7'(c + 1);
              break;
            end
          end
        end else if (pick == 2) begin
          al = 7'($urandom_range(65, 127));
        end
        ents[r] = e;
        declare_res(1'(e / 32), 5'(e % 32), 2'($urandom_range(0, 3)),
                    5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                    1'($urandom_range(0, 1)), al);
      end
      for (int p = 0; p < npass; p++) begin
        logic [1:0] q = 2'($urandom_range(0, 3));
        int         nacc = $urandom_range(1, 3);
        pass_ctr = (pass_ctr + $urandom_range(1, 20)) % 256;
        for (int k = 0; k < nacc; k++) begin
          int e = ents[$urandom_range(0, nres - 1)];
          access_res(1'(e / 32), 5'(e % 32), 8'(pass_ctr), q, 5'($urandom_range(0, 31)));
          accesses++;
        end
        if ($urandom_range(0, 7) == 0) begin
          int e = $urandom_range(0, 63);
          if ($urandom_range(0, 1))
            send_item(rbt_pkg::OP_NONE, rbt_pkg::InDataW'({$urandom, $urandom}));
          else if (!trk_decl[e])
            access_res(1'(e / 32), 5'(e % 32), 8'($urandom), 2'($urandom), 5'($urandom));
        end
      end
      if ($urandom_range(0, 2) != 0)
        send_item(rbt_pkg::OP_FLUSH, rbt_pkg::InDataW'({$urandom, $urandom}));
    end
    send_item(rbt_pkg::OP_FLUSH, '0);
  endtask

  initial begin
    for (int i = 0; i < 64; i++) begin
      trk_decl[i] = 1'b0;
      trk_last[i] = rbt_pkg::NoPass;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_barriers();
    test_aliasing();
    stall_mode = 1;
    test_ignored_items();
    test_flush();
    test_random_frames();
    s_axis_tvalid_i <= 1'b0;
    while (expected_barriers.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
